[rtl/core/upsi_pkg.sv]
// types and constants shared by the unique point set insert unit
// no dependencies

package upsi_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned ENTRY_COUNT_W   = 7;
    localparam int unsigned STATUS_W        = 2;

    localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // y in the upper half, x in the lower half
    typedef struct packed {
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
    } t_point_in;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_result_out;

    // search token walking down the cell chain
    typedef struct packed {
        logic      valid;
        logic      hit;
        t_point_in key;
    } t_probe;

endpackage

[rtl/core/upsi_cell.sv]
// one table cell: holds a stored point and compares the passing probe
// depends on upsi_pkg

module upsi_cell #(
    parameter int unsigned TABLE_DEPTH = upsi_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned INDEX       = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  upsi_pkg::t_probe                    i_probe,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_count,
    input  logic                                i_wr_en,
    input  upsi_pkg::t_point_in                 i_wr_key,
    output upsi_pkg::t_probe                    o_probe
);
    import upsi_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_point_in r_entry;
    t_probe    r_probe;
    t_probe    n_probe;
    logic      w_live;
    logic      w_wr;

    // only entries below the count hold real points
    assign w_live = (CW'(INDEX) < i_count);
    assign w_wr   = i_wr_en && (i_count == CW'(INDEX));

    always_comb begin
        n_probe     = i_probe;
        n_probe.hit = i_probe.hit || (i_probe.valid && w_live && (r_entry == i_probe.key));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.hit <= n_probe.hit;
        r_probe.key <= n_probe.key;
        if (w_wr) begin
            r_entry <= i_wr_key;
        end
    end

    assign o_probe = r_probe;

endmodule

[rtl/core/unique_point_set_insert_unit.sv]
// Insert-if-absent set of 2D points in signed Q16.16. Each item walks a chain of
// TABLE_DEPTH cells, one cell per cycle, and collects an exact match flag; the
// result is then settled and, if new and there is room, the point is written at the
// end of the table. One item is in the chain at a time: the input is held off until
// the result of the last item is settled, so the unit cannot take a new item before
// it is through with the last one; the next item can be accepted in the same cycle
// that the result is presented. The next item is accepted while a result still
// waits on the output; if that result is still held when the next item leaves the
// chain, settling and the input stall until it is taken. A full table drops new
// points with status full.
// depends on upsi_pkg and upsi_cell

module unique_point_set_insert_unit #(
    parameter int unsigned TABLE_DEPTH = upsi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  upsi_pkg::t_point_in    i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output upsi_pkg::t_result_out  o_out_item
);
    import upsi_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_probe          w_chain [0:TABLE_DEPTH];
    logic            r_busy;
    logic            r_fin_valid;
    logic            r_fin_hit;
    t_point_in       r_fin_key;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    t_result_out     r_out_item;
    t_result_out     n_out_item;
    logic            w_in_acc;
    logic            w_commit;
    logic            w_wr_en;
    logic [CW+ENTRY_COUNT_W-1:0] w_count_ext;

    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid && !r_busy;
    assign w_commit   = r_fin_valid && (!r_out_valid || i_out_ready);

    assign w_chain[0] = {w_in_acc, 1'b0, i_in_item};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        upsi_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .INDEX       (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_probe  (w_chain[g]),
            .i_count  (r_count),
            .i_wr_en  (w_wr_en),
            .i_wr_key (r_fin_key),
            .o_probe  (w_chain[g+1])
        );
    end

    // settle the item once its probe has left the last cell
    always_comb begin
        n_count    = r_count;
        w_wr_en    = 1'b0;
        n_out_item.status = STATUS_FULL;
        if (r_fin_hit) begin
            n_out_item.status = STATUS_PRESENT;
        end else if (r_count < CW'(TABLE_DEPTH)) begin
            n_out_item.status = STATUS_ADDED;
            n_count           = r_count + 1'b1;
            w_wr_en           = w_commit;
        end
        w_count_ext            = {{ENTRY_COUNT_W{1'b0}}, n_count};
        n_out_item.entry_count = w_count_ext[ENTRY_COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fin_valid <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_chain[TABLE_DEPTH].valid) begin
                r_fin_valid <= 1'b1;
            end else if (w_commit) begin
                r_fin_valid <= 1'b0;
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_chain[TABLE_DEPTH].valid) begin
            r_fin_hit <= w_chain[TABLE_DEPTH].hit;
            r_fin_key <= w_chain[TABLE_DEPTH].key;
        end
        if (w_commit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[test/tb_unique_point_set_insert_unit.sv]
// testbench for unique_point_set_insert_unit: sends 2D points, predicts status and
// entry count of every item and checks each result in arrival order
// depends on upsi_pkg and the rtl of the insert unit

module tb_unique_point_set_insert_unit;
    import upsi_pkg::*;

    localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef enum int unsigned {
        RX_FREE,
        RX_COIN,
        RX_BEAT,
        RX_SLOW
    } t_rx_mode;

    class point_set_scoreboard;
        logic [63:0]  stored_points[DEPTH];
        int unsigned  stored_total;
        t_result_out  expected_results[$];
        int unsigned  mismatches;

        function new();
            stored_total = 0;
            mismatches   = 0;
        endfunction

        // search before append, so a full table still reports a known point as present
        function void note_point(t_point_in pt);
            logic [63:0] key;
            t_result_out res;
            bit          found;
            key   = pt;
            found = 1'b0;
            for (int unsigned i = 0; i < stored_total; i++) begin
                if (stored_points[i] == key) found = 1'b1;
            end
            if (found) begin
                res.status = STATUS_PRESENT;
            end else if (stored_total < DEPTH) begin
                stored_points[stored_total] = key;
                stored_total++;
                res.status = STATUS_ADDED;
            end else begin
                res.status = STATUS_FULL;
            end
            res.entry_count = stored_total[ENTRY_COUNT_W-1:0];
            expected_results = {expected_results, res};
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        task check_result(t_result_out got);
            t_result_out want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with no item waiting: status %0d count %0d",
                                          got.status, got.entry_count));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry count %0d, expected %0d",
                                              got.entry_count, want.entry_count));
            end
        endtask

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_point_in   i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_result_out o_out_item;

    point_set_scoreboard sb;
    t_point_in           sent_points[$];
    int unsigned         cycle_count = 0;
    t_rx_mode            rx_mode     = RX_FREE;
    int unsigned         rx_left     = 0;

    unique_point_set_insert_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_unique_point_set_insert_unit: FAIL");
            $finish;
        end
    end

    function automatic t_point_in make_point(logic [31:0] x, logic [31:0] y);
        t_point_in pt;
        pt.point_x = x;
        pt.point_y = y;
        return pt;
    endfunction

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            5:       return 32'hFFFF_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // mostly repeats and one-bit near misses of earlier points, so the table sees
    // hits, misses by a single bit, and later full-table drops
    function automatic t_point_in next_random_point();
        t_point_in   pt;
        logic [63:0] bits;
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        if (sent_points.size() != 0 && pick < 45) begin
            pt = sent_points[$urandom_range(0, sent_points.size() - 1)];
        end else if (sent_points.size() != 0 && pick < 65) begin
            bits = sent_points[$urandom_range(0, sent_points.size() - 1)];
            idx  = $urandom_range(0, 63);
            bits = bits ^ (64'd1 << idx);
            pt   = bits;
        end else if (pick < 75) begin
            pt = make_point(corner_value(), corner_value());
        end else begin
            pt = make_point($urandom, $urandom);
        end
        return pt;
    endfunction

    // entered just after a rising edge, returns at the edge that accepted the item
    task automatic send_point(t_point_in pt);
        i_in_valid <= 1'b1;
        i_in_item  <= pt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_point(pt);
        sent_points = {sent_points, pt};
    endtask

    task automatic idle_inputs(int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // receiver: a fresh stall pattern every stretch of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: i_out_ready <= 1'b1;
                RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                RX_BEAT: i_out_ready <= (rx_left % 16) < 6;
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        t_point_in   directed[$];
        int unsigned burst;
        int unsigned sent;
        int unsigned k;

        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, swapped coordinates, sign bit on one side only, exact repeats
        directed = {
            make_point(32'h0000_0000, 32'h0000_0000),
            make_point(32'h0000_0000, 32'h0000_0000),
            make_point(32'h0000_0001, 32'h0000_0000),
            make_point(32'h0000_0000, 32'h0000_0001),
            make_point(32'h8000_0000, 32'h8000_0000),
            make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            make_point(32'h8000_0000, 32'h7FFF_FFFF),
            make_point(32'h7FFF_FFFF, 32'h8000_0000),
            make_point(32'hFFFF_FFFF, 32'hFFFF_FFFF),
            make_point(32'hFFFF_FFFF, 32'h0000_0000),
            make_point(32'h0000_0000, 32'hFFFF_FFFF),
            make_point(32'h0001_0000, 32'hFFFF_0000),
            make_point(32'hFFFF_0000, 32'h0001_0000),
            make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            make_point(32'h8000_0000, 32'h8000_0000),
            make_point(32'h0001_0000, 32'hFFFF_0000),
            make_point(32'h0001_0001, 32'hFFFF_0000),
            make_point(32'h8000_0000, 32'h0000_0000),
            make_point(32'h0000_0000, 32'h8000_0000),
            make_point(32'h0000_0001, 32'h0000_0000)
        };
        foreach (directed[i]) send_point(directed[i]);
        idle_inputs($urandom_range(1, 20));

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_point(next_random_point());
                sent++;
            end
            idle_inputs($urandom_range(1, 80));
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_unique_point_set_insert_unit: PASS");
        end else begin
            $display("tb_unique_point_set_insert_unit: FAIL");
        end
        $finish;
    end

endmodule

[unique_point_set_insert_unit.f]
rtl/core/upsi_pkg.sv
rtl/core/upsi_cell.sv
rtl/core/unique_point_set_insert_unit.sv
test/tb_unique_point_set_insert_unit.sv
